### hw/rtl/mi3_pkg.sv
package mi3_pkg;

  // Field and datapath widths
  localparam int MOD_W       = 16;
  localparam int ELEM_W      = 16;
  localparam int NUM_ELEM    = 9;
  localparam int SLOT_W      = $clog2(NUM_ELEM);
  localparam int MUL_STEPS   = ELEM_W;
  localparam int STEP_W      = $clog2(MUL_STEPS);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int POS_W       = 2;
  localparam int OUT_DATA_W  = ((MOD_W + 2 * POS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_DATA_W - MOD_W - 2 * POS_W;
  localparam int MOD_RESET   = 26;

  typedef logic [MOD_W-1:0]  mod_t;
  typedef logic [ELEM_W-1:0] elem_t;
  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [POS_W-1:0]  pos_t;

  localparam slot_t LAST_SLOT = slot_t'(NUM_ELEM - 1);
  localparam slot_t DET_LAST  = slot_t'(2);

  // Queue entry: element with the modulus in force when it arrived
  typedef struct packed {
    elem_t element;
    mod_t  modulus;
    slot_t slot;
  } q_item_t;

  // Request to the modular multiplier
  typedef struct packed {
    logic  start;
    mod_t  a;
    elem_t b;
  } mm_req_t;

  // One result item
  typedef struct packed {
    mod_t value;
    pos_t row;
    pos_t col;
    logic invertible;
    logic last;
  } res_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_LOAD,
    BK_RENORM,
    BK_COF,
    BK_DET,
    BK_INV,
    BK_PROD,
    BK_EMIT,
    BK_FAIL
  } bk_state_t;

  // Store addresses of the two products of one cofactor: pa*pb - qa*qb
  typedef struct packed {
    slot_t pa;
    slot_t pb;
    slot_t qa;
    slot_t qb;
  } cof_pick_t;

  function automatic cof_pick_t cof_pick(input slot_t k);
    cof_pick_t p;
    case (k)
      slot_t'(0): p = '{slot_t'(4), slot_t'(8), slot_t'(5), slot_t'(7)};
      slot_t'(1): p = '{slot_t'(5), slot_t'(6), slot_t'(3), slot_t'(8)};
      slot_t'(2): p = '{slot_t'(3), slot_t'(7), slot_t'(4), slot_t'(6)};
      slot_t'(3): p = '{slot_t'(7), slot_t'(2), slot_t'(8), slot_t'(1)};
      slot_t'(4): p = '{slot_t'(8), slot_t'(0), slot_t'(6), slot_t'(2)};
      slot_t'(5): p = '{slot_t'(6), slot_t'(1), slot_t'(7), slot_t'(0)};
      slot_t'(6): p = '{slot_t'(1), slot_t'(5), slot_t'(2), slot_t'(4)};
      slot_t'(7): p = '{slot_t'(2), slot_t'(3), slot_t'(0), slot_t'(5)};
      slot_t'(8): p = '{slot_t'(0), slot_t'(4), slot_t'(1), slot_t'(3)};
      default:    p = '0;
    endcase
    return p;
  endfunction

  // Adjugate entry (r,c) takes the cofactor of element (c,r)
  function automatic slot_t transpose_of(input slot_t k);
    slot_t t;
    case (k)
      slot_t'(0): t = slot_t'(0);
      slot_t'(1): t = slot_t'(3);
      slot_t'(2): t = slot_t'(6);
      slot_t'(3): t = slot_t'(1);
      slot_t'(4): t = slot_t'(4);
      slot_t'(5): t = slot_t'(7);
      slot_t'(6): t = slot_t'(2);
      slot_t'(7): t = slot_t'(5);
      slot_t'(8): t = slot_t'(8);
      default:    t = '0;
    endcase
    return t;
  endfunction

  // Row and column of a row-major position
  function automatic logic [2*POS_W-1:0] pos_of(input slot_t k);
    logic [2*POS_W-1:0] rc;
    case (k)
      slot_t'(0): rc = {pos_t'(0), pos_t'(0)};
      slot_t'(1): rc = {pos_t'(0), pos_t'(1)};
      slot_t'(2): rc = {pos_t'(0), pos_t'(2)};
      slot_t'(3): rc = {pos_t'(1), pos_t'(0)};
      slot_t'(4): rc = {pos_t'(1), pos_t'(1)};
      slot_t'(5): rc = {pos_t'(1), pos_t'(2)};
      slot_t'(6): rc = {pos_t'(2), pos_t'(0)};
      slot_t'(7): rc = {pos_t'(2), pos_t'(1)};
      slot_t'(8): rc = {pos_t'(2), pos_t'(2)};
      default:    rc = '0;
    endcase
    return rc;
  endfunction

endpackage

### hw/rtl/mi3_front.sv
module mi3_front import mi3_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  elem_t   in_element,
  input  logic    cfg_wen,
  input  mod_t    cfg_wdata,
  output logic    q_push,
  output q_item_t q_item,
  input  logic    q_full
);

  mod_t  modulus_r, modulus_nxt;
  slot_t load_count_r, load_count_nxt;

  // Accept whenever the queue has room
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // Tag each element with its store slot and the modulus in force
  assign q_item = '{element: in_element, modulus: modulus_r, slot: load_count_r};

  always_comb begin
    modulus_nxt    = cfg_wen ? cfg_wdata : modulus_r;
    load_count_nxt = load_count_r;
    if (q_push) begin
      load_count_nxt = (load_count_r == LAST_SLOT) ? '0 : load_count_r + slot_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r    <= mod_t'(MOD_RESET);
      load_count_r <= '0;
    end else begin
      modulus_r    <= modulus_nxt;
      load_count_r <= load_count_nxt;
    end
  end

endmodule

### hw/rtl/mi3_fifo.sv
module mi3_fifo import mi3_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  q_item_t push_item,
  output logic    full,
  input  logic    pop,
  output q_item_t pop_item,
  output logic    not_empty
);

  q_item_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]   count_r;
  logic                do_push, do_pop;

  assign full      = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_item  = mem_r[rd_ptr_r];

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + QCNT_W'(1);
        2'b01:   count_r <= count_r - QCNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

### hw/rtl/mi3_mulmod.sv
module mi3_mulmod import mi3_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  mm_req_t req,
  input  mod_t    modulus,
  output logic    done,
  output mod_t    result
);

  logic              busy_r, done_r;
  logic [STEP_W-1:0] step_r;
  mod_t              acc_r, a_r;
  elem_t             b_r;
  logic [MOD_W+1:0]  t0, t1, t2, m_ext;
  mod_t              acc_step;

  // One bit of b per cycle, msb first: acc = 2*acc + bit*a, brought below m
  always_comb begin
    m_ext    = {2'b00, modulus};
    t0       = {1'b0, acc_r, 1'b0} + {2'b00, (b_r[ELEM_W-1] ? a_r : mod_t'(0))};
    t1       = (t0 >= m_ext) ? t0 - m_ext : t0;
    t2       = (t1 >= m_ext) ? t1 - m_ext : t1;
    acc_step = t2[MOD_W-1:0];
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      acc_r <= '0;
      a_r   <= req.a;
      b_r   <= req.b;
    end else if (busy_r) begin
      acc_r <= acc_step;
      b_r   <= {b_r[ELEM_W-2:0], 1'b0};
    end
  end

  // Step counter and completion pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + STEP_W'(1);
        if (step_r == STEP_W'(MUL_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done   = done_r;
  assign result = acc_r;

endmodule

### hw/rtl/mi3_back.sv
module mi3_back import mi3_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    q_valid,
  input  q_item_t q_item,
  output logic    q_pop,
  output mm_req_t mm_req,
  output mod_t    mm_modulus,
  input  logic    mm_done,
  input  mod_t    mm_result,
  output logic    out_valid,
  input  logic    out_ready,
  output res_t    out_res
);

  bk_state_t  st_r, st_nxt;
  logic [1:0] ph_r, ph_nxt;
  slot_t      idx_r, idx_nxt;
  slot_t      slot_r, slot_nxt;
  logic       half_r, half_nxt;
  mod_t       m_r, m_nxt;
  mod_t       opa_r, opa_nxt;
  mod_t       p_r, p_nxt;
  mod_t       det_r, det_nxt;
  mod_t       x_r, x_nxt;
  mod_t       pd_r, pd_nxt;
  mod_t       inv_r, inv_nxt;

  elem_t      store_r [NUM_ELEM];
  mod_t       cof_r [NUM_ELEM];

  logic       st_wen;
  slot_t      st_waddr;
  elem_t      st_wdata;
  logic       cof_wen;
  mod_t       cof_wdata;
  slot_t      s_addr, c_addr;
  elem_t      s_rd;
  mod_t       c_rd;
  cof_pick_t  pick;
  mod_t       det_sum;
  logic [2*POS_W-1:0] emit_pos;

  logic       out_valid_r;
  res_t       out_res_r, out_res_nxt;
  logic       out_load, out_free;

  function automatic mod_t add_mod(input mod_t a, input mod_t b, input mod_t m);
    logic [MOD_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s >= {1'b0, m}) ? mod_t'(s - {1'b0, m}) : mod_t'(s);
  endfunction

  function automatic mod_t sub_mod(input mod_t p, input mod_t q, input mod_t m);
    logic [MOD_W:0] s;
    s = {1'b0, p} + {1'b0, m} - {1'b0, q};
    return (p >= q) ? p - q : mod_t'(s);
  endfunction

  // Single read port on each register file
  assign s_rd = store_r[s_addr];
  assign c_rd = cof_r[c_addr];

  assign pick       = cof_pick(idx_r);
  assign emit_pos   = pos_of(idx_r);
  assign det_sum    = add_mod(det_r, mm_result, m_r);
  assign mm_modulus = m_r;
  assign out_free   = !out_valid_r || out_ready;

  // Sequencer: next state, multiplier requests, store writes, result load
  always_comb begin
    st_nxt      = st_r;
    ph_nxt      = ph_r;
    idx_nxt     = idx_r;
    slot_nxt    = slot_r;
    half_nxt    = half_r;
    m_nxt       = m_r;
    opa_nxt     = opa_r;
    p_nxt       = p_r;
    det_nxt     = det_r;
    x_nxt       = x_r;
    pd_nxt      = pd_r;
    inv_nxt     = inv_r;
    q_pop       = 1'b0;
    mm_req      = '0;
    st_wen      = 1'b0;
    st_waddr    = slot_r;
    st_wdata    = elem_t'(mm_result);
    cof_wen     = 1'b0;
    cof_wdata   = sub_mod(p_r, mm_result, m_r);
    s_addr      = idx_r;
    c_addr      = idx_r;
    out_load    = 1'b0;
    out_res_nxt = out_res_r;

    case (st_r)
      // Take the next element; reduce it unless the modulus is zero
      BK_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          m_nxt    = q_item.modulus;
          slot_nxt = q_item.slot;
          if (q_item.modulus == '0) begin
            st_wen   = 1'b1;
            st_waddr = q_item.slot;
            st_wdata = q_item.element;
            if (q_item.slot == LAST_SLOT) begin
              det_nxt = '0;
              st_nxt  = BK_FAIL;
            end
          end else begin
            mm_req.start = 1'b1;
            mm_req.a     = (q_item.modulus == mod_t'(1)) ? '0 : mod_t'(1);
            mm_req.b     = q_item.element;
            st_nxt       = BK_LOAD;
          end
        end
      end

      BK_LOAD: begin
        if (mm_done) begin
          st_wen = 1'b1;
          if (slot_r != LAST_SLOT) begin
            st_nxt = BK_IDLE;
          end else if (m_r < mod_t'(2)) begin
            det_nxt = '0;
            st_nxt  = BK_FAIL;
          end else begin
            idx_nxt = '0;
            ph_nxt  = '0;
            st_nxt  = BK_RENORM;
          end
        end
      end

      // Reduce every stored element by the current modulus
      BK_RENORM: begin
        if (ph_r == 2'd0) begin
          mm_req.start = 1'b1;
          mm_req.a     = mod_t'(1);
          mm_req.b     = s_rd;
          ph_nxt       = 2'd1;
        end else if (mm_done) begin
          st_wen   = 1'b1;
          st_waddr = idx_r;
          ph_nxt   = 2'd0;
          if (idx_r == LAST_SLOT) begin
            idx_nxt  = '0;
            half_nxt = 1'b0;
            st_nxt   = BK_COF;
          end else begin
            idx_nxt = idx_r + slot_t'(1);
          end
        end
      end

      // Nine cofactors, two products each
      BK_COF: begin
        case (ph_r)
          2'd0: begin
            s_addr  = half_r ? pick.qa : pick.pa;
            opa_nxt = mod_t'(s_rd);
            ph_nxt  = 2'd1;
          end
          2'd1: begin
            s_addr       = half_r ? pick.qb : pick.pb;
            mm_req.start = 1'b1;
            mm_req.a     = opa_r;
            mm_req.b     = s_rd;
            ph_nxt       = 2'd2;
          end
          2'd2: begin
            if (mm_done) begin
              ph_nxt = 2'd0;
              if (!half_r) begin
                p_nxt    = mm_result;
                half_nxt = 1'b1;
              end else begin
                cof_wen  = 1'b1;
                half_nxt = 1'b0;
                if (idx_r == LAST_SLOT) begin
                  idx_nxt = '0;
                  det_nxt = '0;
                  st_nxt  = BK_DET;
                end else begin
                  idx_nxt = idx_r + slot_t'(1);
                end
              end
            end
          end
          default: ph_nxt = 2'd0;
        endcase
      end

      // Determinant by expansion along the top row
      BK_DET: begin
        case (ph_r)
          2'd0: begin
            opa_nxt = mod_t'(s_rd);
            ph_nxt  = 2'd1;
          end
          2'd1: begin
            mm_req.start = 1'b1;
            mm_req.a     = opa_r;
            mm_req.b     = elem_t'(c_rd);
            ph_nxt       = 2'd2;
          end
          2'd2: begin
            if (mm_done) begin
              det_nxt = det_sum;
              ph_nxt  = 2'd0;
              if (idx_r == DET_LAST) begin
                x_nxt  = mod_t'(1);
                pd_nxt = det_sum;
                st_nxt = (det_sum == '0) ? BK_FAIL : BK_INV;
              end else begin
                idx_nxt = idx_r + slot_t'(1);
              end
            end
          end
          default: ph_nxt = 2'd0;
        endcase
      end

      // Search x = 1.. for det*x == 1, one candidate a cycle
      BK_INV: begin
        if (pd_r == mod_t'(1)) begin
          inv_nxt = x_r;
          idx_nxt = '0;
          ph_nxt  = '0;
          st_nxt  = BK_PROD;
        end else if (x_r == m_r - mod_t'(1)) begin
          st_nxt = BK_FAIL;
        end else begin
          x_nxt  = x_r + mod_t'(1);
          pd_nxt = add_mod(pd_r, det_r, m_r);
        end
      end

      // Inverse entry = transposed cofactor times inverse determinant
      BK_PROD: begin
        c_addr = transpose_of(idx_r);
        if (ph_r == 2'd0) begin
          mm_req.start = 1'b1;
          mm_req.a     = c_rd;
          mm_req.b     = elem_t'(inv_r);
          ph_nxt       = 2'd1;
        end else if (mm_done) begin
          p_nxt  = mm_result;
          ph_nxt = 2'd0;
          st_nxt = BK_EMIT;
        end
      end

      BK_EMIT: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_res_nxt = '{value: p_r, row: emit_pos[2*POS_W-1:POS_W],
                          col: emit_pos[POS_W-1:0], invertible: 1'b1,
                          last: (idx_r == LAST_SLOT)};
          if (idx_r == LAST_SLOT) begin
            idx_nxt = '0;
            st_nxt  = BK_IDLE;
          end else begin
            idx_nxt = idx_r + slot_t'(1);
            st_nxt  = BK_PROD;
          end
        end
      end

      // Single result for a singular matrix
      BK_FAIL: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_res_nxt = '{value: '0, row: '0, col: '0, invertible: 1'b0, last: 1'b1};
          inv_nxt     = '0;
          st_nxt      = BK_IDLE;
        end
      end

      default: st_nxt = BK_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= BK_IDLE;
      ph_r        <= '0;
      idx_r       <= '0;
      half_r      <= 1'b0;
      det_r       <= '0;
      inv_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      ph_r   <= ph_nxt;
      idx_r  <= idx_nxt;
      half_r <= half_nxt;
      det_r  <= det_nxt;
      inv_r  <= inv_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
    m_r    <= m_nxt;
    opa_r  <= opa_nxt;
    p_r    <= p_nxt;
    x_r    <= x_nxt;
    pd_r   <= pd_nxt;
    if (out_load) begin
      out_res_r <= out_res_nxt;
    end
  end

  // Matrix and cofactor register files
  always_ff @(posedge clk) begin
    if (st_wen) begin
      store_r[st_waddr] <= st_wdata;
    end
    if (cof_wen) begin
      cof_r[idx_r] <= cof_wdata;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

### hw/rtl/matrix3_modular_inverse_unit.sv
// 3x3 matrix inverse modulo m, as used for Hill cipher key setup.
// Input stream: nine 16-bit elements per matrix in row-major order on in_tdata.
// Output stream: nine inverse entries in row-major order, row and column in
// out_tdata, out_tuser set, out_tlast on the ninth; or, for a singular matrix,
// one item with out_tuser clear, zero data and out_tlast set.
// cfg_wen/cfg_wdata write the modulus (reset value 26); write it between
// matrices or between elements while no result is pending.
// Elements enter a two-deep queue; each one is then reduced, unless the modulus
// is zero, by a bit-serial modular multiplier (one multiplier bit per cycle);
// the next element leaves the queue only once the last one is stored. After the
// ninth element the block re-reduces the store, forms nine cofactors and the
// determinant (30 products), searches the inverse determinant one candidate per
// cycle (up to modulus-1 candidates), then forms the nine outputs.
// Reset empties the queue, drops any result in flight and restores the
// modulus. A stalled receiver holds the output register; the queue keeps
// taking elements until it is full.
module matrix3_modular_inverse_unit import mi3_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [ELEM_W-1:0]     in_tdata,    // [15:0] element
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,   // [15:0] value, [17:16] row, [19:18] col
  output logic                  out_tuser,   // [0] invertible
  output logic                  out_tlast,
  input  logic                  cfg_wen,
  input  logic [MOD_W-1:0]      cfg_wdata
);

  logic    q_push, q_full, q_pop, q_valid;
  q_item_t q_in, q_out;
  mm_req_t mm_req;
  mod_t    mm_modulus, mm_result;
  logic    mm_done;
  res_t    res;

  mi3_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_element (in_tdata),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .q_push     (q_push),
    .q_item     (q_in),
    .q_full     (q_full)
  );

  mi3_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_out),
    .not_empty (q_valid)
  );

  mi3_mulmod u_mulmod (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mm_req),
    .modulus (mm_modulus),
    .done    (mm_done),
    .result  (mm_result)
  );

  mi3_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_out),
    .q_pop      (q_pop),
    .mm_req     (mm_req),
    .mm_modulus (mm_modulus),
    .mm_done    (mm_done),
    .mm_result  (mm_result),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_res    (res)
  );

  // Pack the result item onto the stream
  assign out_tdata = {{OUT_PAD_W{1'b0}}, res.col, res.row, res.value};
  assign out_tuser = res.invertible;
  assign out_tlast = res.last;

  // Singular result is a lone, all-zero, final item
  a_fail_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tlast && out_tdata == '0))
    else $error("singular result not a lone zero item");

  // Row and column stay inside the 3x3 grid
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[17:16] != 2'd3) && (out_tdata[19:18] != 2'd3))
    else $error("inverse entry position out of range");

  // Last inverse entry is the bottom-right one
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser && out_tlast) |->
      (out_tdata[17:16] == 2'd2) && (out_tdata[19:18] == 2'd2))
    else $error("last marks an entry other than (2,2)");

  // Nothing offered right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

### test/matrix3_modular_inverse_checker.sv
// Watches the element, result and modulus channels of the matrix inverse unit.
// Keeps its own copy of the modulus and the element store, works out the
// inverse of each complete matrix and compares every result item against it.
module mi3_inverse_checker import mi3_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [ELEM_W-1:0]     in_tdata,    // [15:0] element
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,   // [15:0] value, [17:16] row, [19:18] col
  input  logic                  out_tuser,   // [0] invertible
  input  logic                  out_tlast,
  input  logic                  cfg_wen,
  input  logic [MOD_W-1:0]      cfg_wdata,
  output int                    fail_count,
  output int                    pending,
  output int                    matrix_count,
  output int                    singular_count,
  output int                    result_count
);

  typedef struct {
    logic [MOD_W-1:0] value;
    logic [1:0]       row;
    logic [1:0]       col;
    logic             invertible;
    logic             last;
  } inv_entry_t;

  inv_entry_t       inverse_q[$];
  mod_t             cur_modulus;
  elem_t            key_store[NUM_ELEM];
  int unsigned      fill_count;

  // 2x2 minor of element (r,c) with the cyclic sign built in, mod m
  function automatic longint unsigned minor_mod(int r, int c, longint unsigned m);
    longint unsigned a, b, p, q;
    a = key_store[((r + 1) % 3) * 3 + (c + 1) % 3];
    b = key_store[((r + 2) % 3) * 3 + (c + 2) % 3];
    p = (a * b) % m;
    a = key_store[((r + 1) % 3) * 3 + (c + 2) % 3];
    b = key_store[((r + 2) % 3) * 3 + (c + 1) % 3];
    q = (a * b) % m;
    return (p + m - q) % m;
  endfunction

  // Determinant, inverse search and adjugate entries for a full store
  task automatic predict_inverse();
    longint unsigned m, det, inv, x, a;
    int              k;
    bit              found;
    inv_entry_t      e;
    m     = cur_modulus;
    found = 1'b0;
    inv   = 0;
    if (m >= 2) begin
      // stored elements may predate a modulus change
      for (k = 0; k < NUM_ELEM; k++) key_store[k] = elem_t'(key_store[k] % m);
      det = 0;
      for (k = 0; k < 3; k++) begin
        a   = key_store[k];
        det = (det + (a * minor_mod(0, k, m)) % m) % m;
      end
      for (x = 1; x < m && !found; x++) begin
        if ((det * x) % m == 1) begin
          inv   = x;
          found = 1'b1;
        end
      end
    end
    if (!found) begin
      e = '{value: '0, row: '0, col: '0, invertible: 1'b0, last: 1'b1};
      inverse_q.push_back(e);
      singular_count++;
    end else begin
      for (k = 0; k < NUM_ELEM; k++) begin
        e.value      = mod_t'((minor_mod(k % 3, k / 3, m) * inv) % m);
        e.row        = 2'(k / 3);
        e.col        = 2'(k % 3);
        e.invertible = 1'b1;
        e.last       = (k == NUM_ELEM - 1);
        inverse_q.push_back(e);
      end
    end
  endtask

  function automatic void check_field(string name, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Sample all channels at the clock edge, before the edge's updates land
  always @(posedge clk) begin : monitor
    inv_entry_t want;
    elem_t      elem;
    if (!rst_n) begin
      cur_modulus = mod_t'(MOD_RESET);
      fill_count  = 0;
      inverse_q.delete();
    end else begin
      if (cfg_wen) cur_modulus = cfg_wdata;

      // element item
      if (in_tvalid && in_tready) begin
        elem = in_tdata;
        if (cur_modulus != 0) elem = elem_t'(elem % cur_modulus);
        key_store[fill_count] = elem;
        fill_count++;
        if (fill_count == NUM_ELEM) begin
          fill_count = 0;
          matrix_count++;
          predict_inverse();
        end
      end

      // result item
      if (out_tvalid && out_tready) begin
        result_count++;
        if (inverse_q.size() == 0) begin
          $error("unexpected result item: value %0d row %0d col %0d",
                 out_tdata[15:0], out_tdata[17:16], out_tdata[19:18]);
          fail_count++;
        end else begin
          want = inverse_q.pop_front();
          check_field("value", want.value, out_tdata[15:0]);
          check_field("row", want.row, out_tdata[17:16]);
          check_field("col", want.col, out_tdata[19:18]);
          check_field("invertible", want.invertible, out_tuser);
          check_field("last", want.last, out_tlast);
        end
      end
    end
    pending <= inverse_q.size();
  end

endmodule

### test/tb_matrix3_modular_inverse_unit.sv
// Stimulus and verdict for the matrix inverse unit; checking is done by
// the checker instance beside the block.
module tb_matrix3_modular_inverse_unit;
  import mi3_pkg::*;

  localparam int CYCLE_LIMIT   = 2_500_000;
  localparam int SETTLE_CYCLES = 200;
  localparam int NUM_PHASES    = 13;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [ELEM_W-1:0]     in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;
  logic                  cfg_wen    = 1'b0;
  logic [MOD_W-1:0]      cfg_wdata  = '0;

  int fail_count, pending, matrix_count, singular_count, result_count;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int cycle_count = 0;
  int elements_sent = 0;
  int modulus_writes = 0;

  mod_t phase_mod[NUM_PHASES];
  int   phase_mats[NUM_PHASES];

  always #2 clk = ~clk;

  matrix3_modular_inverse_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata)
  );

  mi3_inverse_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .out_tlast      (out_tlast),
    .cfg_wen        (cfg_wen),
    .cfg_wdata      (cfg_wdata),
    .fail_count     (fail_count),
    .pending        (pending),
    .matrix_count   (matrix_count),
    .singular_count (singular_count),
    .result_count   (result_count)
  );

  // Receiver back-pressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // One element item, with random idle cycles in front
  task automatic send_element(input elem_t value);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    elements_sent++;
  endtask

  // Stop sending, wait for every expected result, then let the queue drain
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_modulus(input mod_t value);
    settle();
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    modulus_writes++;
  endtask

  // Random matrix: mostly full-range, some with a repeated row, some tiny
  task automatic send_matrix();
    elem_t cells[NUM_ELEM];
    int    kind;
    int    k;
    kind = $urandom_range(9);
    for (k = 0; k < NUM_ELEM; k++)
      cells[k] = (kind >= 8) ? elem_t'($urandom_range(7)) : elem_t'($urandom);
    if (kind == 6 || kind == 7)
      for (k = 6; k < NUM_ELEM; k++) cells[k] = cells[k - 6];
    for (k = 0; k < NUM_ELEM; k++) send_element(cells[k]);
  endtask

  initial begin : stimulus
    int p;
    int k;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: identity, all-ones singular, modulus dropped to zero mid-load
    tx_idle_pct = 21;
    rx_idle_pct = 60;
    for (k = 0; k < NUM_ELEM; k++) send_element((k % 4 == 0) ? elem_t'(1) : elem_t'(0));
    repeat (NUM_ELEM) send_element(16'hFFFF);
    send_element(16'h8000);
    send_element(16'h7FFF);
    send_element(16'h5555);
    send_element(16'hAAAA);
    write_modulus(mod_t'(0));
    send_element(16'h0000);
    send_element(16'h0001);
    send_element(16'hFFFF);
    send_element(16'h1234);
    send_element(16'hFEDC);

    // random phases: modulus and matrix count per phase
    phase_mod  = '{mod_t'(1), mod_t'(2), mod_t'(26), mod_t'($urandom_range(4, 300)),
                   mod_t'(3), mod_t'(29), mod_t'(65521), mod_t'($urandom_range(300, 5000)),
                   mod_t'(256), mod_t'(65535), mod_t'($urandom_range(2, 65535)),
                   mod_t'(26), mod_t'(7)};
    phase_mats = '{2, 5, 6, 5, 4, 5, 2, 4, 5, 1, 1, 5, 4};
    for (p = 0; p < NUM_PHASES; p++) begin
      if (p < 5) begin
        tx_idle_pct = 21;
        rx_idle_pct = 60;
      end else if (p < 9) begin
        tx_idle_pct = 60;
        rx_idle_pct = 21;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      // sometimes change the modulus part way through a matrix
      if (p > 0 && $urandom_range(2) == 0)
        repeat ($urandom_range(1, 8)) send_element(elem_t'($urandom));
      write_modulus(phase_mod[p]);
      repeat (phase_mats[p]) send_matrix();
    end
    while (elements_sent % NUM_ELEM != 0) send_element(elem_t'($urandom));
    settle();

    $display("Run covered %0d elements, %0d matrices under %0d modulus writes.",
             elements_sent, matrix_count, modulus_writes);
    $display("%0d matrices inverted, %0d singular, %0d result items compared.",
             matrix_count - singular_count, singular_count, result_count);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
